// File: hdl/sorted_set_table_top_macros.svh
// Assertion macros for the sorted set table.
`ifndef SORTED_SET_TABLE_TOP_MACROS_SVH
`define SORTED_SET_TABLE_TOP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sorted set table: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define SST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted set table: next-cycle check failed");

`endif

// File: hdl/sst_pkg.sv
`timescale 1ns / 1ps

package sst_pkg;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_POP    = 2'd2;
	localparam logic [1:0] CMD_NOP    = 2'd3;

	localparam logic [2:0] ST_DONE        = 3'd0;
	localparam logic [2:0] ST_PRESENT     = 3'd1;
	localparam logic [2:0] ST_NOT_PRESENT = 3'd2;
	localparam logic [2:0] ST_FULL        = 3'd3;
	localparam logic [2:0] ST_EMPTY       = 3'd4;

	typedef enum logic [5:0] {
		FSM_IDLE   = 6'b000001,
		FSM_SEARCH = 6'b000010,
		FSM_EXEC   = 6'b000100,
		FSM_SHUP   = 6'b001000,
		FSM_SHDN   = 6'b010000,
		FSM_WKEY   = 6'b100000
	} fsm_t;

endpackage

// File: hdl/sorted_set_table_top.sv
`timescale 1ns / 1ps
// One transaction is taken when start is high and busy is low. Its result appears on the result
// ports for a single cycle with done high and cannot be held off, so it must be captured then.
// Busy falls in that same cycle, so the next transaction can be taken at the edge that ends it.
// The table memory has one read and one write port. It is scanned one entry per cycle up
// to the position of the key, and an insert or delete then moves the entries above that
// position one place per cycle. A pop takes the head without a scan but moves every
// remaining entry down. The unused command code and any command on an empty table skip
// the scan and go straight to the result.
`include "sorted_set_table_top_macros.svh"

module sorted_set_table_top #(
	parameter int CAPACITY = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic signed [31:0] key_value,
	output logic               done,
	output logic [2:0]         status,
	output logic signed [31:0] popped_value,
	output logic [8:0]         entry_count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [31:0] mem [CAPACITY];
	logic signed [31:0] rd_data_q;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [AW-1:0]      mem_ra;
	logic signed [31:0] mem_wd;

	sst_pkg::fsm_t      state_q;
	logic [1:0]         cmd_q;
	logic signed [31:0] key_q;
	logic [AW-1:0]      ptr_q;
	logic [AW-1:0]      src_q;
	logic [CW-1:0]      pos_q;
	logic               found_q;
	logic [CW-1:0]      count_q;
	logic               done_q;
	logic [2:0]         status_q;
	logic signed [31:0] popped_q;

	logic               search_hit;
	logic [CW-1:0]      count_m1;

	assign count_m1   = count_q - CW'(1);
	assign search_hit = (cmd_q == sst_pkg::CMD_POP) || (rd_data_q >= key_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[mem_ra];
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = rd_data_q;
		mem_ra = '0;
		unique case (state_q)
			sst_pkg::FSM_IDLE: begin
				mem_ra = '0;
			end
			sst_pkg::FSM_SEARCH: begin
				mem_ra = ptr_q + AW'(1);
			end
			sst_pkg::FSM_EXEC: begin
				if (cmd_q == sst_pkg::CMD_INSERT) begin
					mem_ra = count_m1[AW-1:0];
					if (!found_q && count_q < CW'(CAPACITY) && pos_q == count_q) begin
						mem_we = 1'b1;
						mem_wa = pos_q[AW-1:0];
						mem_wd = key_q;
					end
				end else begin
					mem_ra = pos_q[AW-1:0] + AW'(1);
				end
			end
			sst_pkg::FSM_SHUP: begin
				mem_we = 1'b1;
				mem_wa = src_q + AW'(1);
				mem_ra = src_q - AW'(1);
			end
			sst_pkg::FSM_SHDN: begin
				mem_we = 1'b1;
				mem_wa = src_q - AW'(1);
				mem_ra = src_q + AW'(1);
			end
			sst_pkg::FSM_WKEY: begin
				mem_we = 1'b1;
				mem_wa = pos_q[AW-1:0];
				mem_wd = key_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sst_pkg::FSM_IDLE;
			cmd_q    <= sst_pkg::CMD_NOP;
			key_q    <= '0;
			ptr_q    <= '0;
			src_q    <= '0;
			pos_q    <= '0;
			found_q  <= 1'b0;
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= sst_pkg::ST_DONE;
			popped_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				sst_pkg::FSM_IDLE: begin
					if (start) begin
						cmd_q    <= command;
						key_q    <= key_value;
						ptr_q    <= '0;
						pos_q    <= '0;
						found_q  <= 1'b0;
						popped_q <= '0;
						if (command == sst_pkg::CMD_NOP || count_q == '0) begin
							state_q <= sst_pkg::FSM_EXEC;
						end else begin
							state_q <= sst_pkg::FSM_SEARCH;
						end
					end
				end
				sst_pkg::FSM_SEARCH: begin
					priority if (search_hit) begin
						pos_q   <= CW'(ptr_q);
						found_q <= (cmd_q == sst_pkg::CMD_POP) || (rd_data_q == key_q);
						if (cmd_q == sst_pkg::CMD_POP) begin
							popped_q <= rd_data_q;
						end
						state_q <= sst_pkg::FSM_EXEC;
					end else if (CW'(ptr_q) == count_m1) begin
						pos_q   <= count_q;
						found_q <= 1'b0;
						state_q <= sst_pkg::FSM_EXEC;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				sst_pkg::FSM_EXEC: begin
					priority if (cmd_q == sst_pkg::CMD_NOP) begin
						status_q <= sst_pkg::ST_DONE;
						done_q   <= 1'b1;
						state_q  <= sst_pkg::FSM_IDLE;
					end else if (cmd_q == sst_pkg::CMD_INSERT) begin
						priority if (found_q) begin
							status_q <= sst_pkg::ST_PRESENT;
							done_q   <= 1'b1;
							state_q  <= sst_pkg::FSM_IDLE;
						end else if (count_q >= CW'(CAPACITY)) begin
							status_q <= sst_pkg::ST_FULL;
							done_q   <= 1'b1;
							state_q  <= sst_pkg::FSM_IDLE;
						end else if (pos_q == count_q) begin
							count_q  <= count_q + CW'(1);
							status_q <= sst_pkg::ST_DONE;
							done_q   <= 1'b1;
							state_q  <= sst_pkg::FSM_IDLE;
						end else begin
							src_q   <= count_m1[AW-1:0];
							state_q <= sst_pkg::FSM_SHUP;
						end
					end else begin
						priority if (!found_q) begin
							status_q <= (cmd_q == sst_pkg::CMD_POP) ? sst_pkg::ST_EMPTY
								: sst_pkg::ST_NOT_PRESENT;
							done_q   <= 1'b1;
							state_q  <= sst_pkg::FSM_IDLE;
						end else if (pos_q == count_m1) begin
							count_q  <= count_m1;
							status_q <= sst_pkg::ST_DONE;
							done_q   <= 1'b1;
							state_q  <= sst_pkg::FSM_IDLE;
						end else begin
							src_q   <= pos_q[AW-1:0] + AW'(1);
							state_q <= sst_pkg::FSM_SHDN;
						end
					end
				end
				sst_pkg::FSM_SHUP: begin
					if (CW'(src_q) == pos_q) begin
						state_q <= sst_pkg::FSM_WKEY;
					end else begin
						src_q <= src_q - AW'(1);
					end
				end
				sst_pkg::FSM_WKEY: begin
					count_q  <= count_q + CW'(1);
					status_q <= sst_pkg::ST_DONE;
					done_q   <= 1'b1;
					state_q  <= sst_pkg::FSM_IDLE;
				end
				sst_pkg::FSM_SHDN: begin
					if (CW'(src_q) == count_m1) begin
						count_q  <= count_m1;
						status_q <= sst_pkg::ST_DONE;
						done_q   <= 1'b1;
						state_q  <= sst_pkg::FSM_IDLE;
					end else begin
						src_q <= src_q + AW'(1);
					end
				end
				default: begin
					state_q <= sst_pkg::FSM_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != sst_pkg::FSM_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign popped_value = popped_q;
	assign entry_count  = 9'(count_q);

	`SST_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`SST_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy)
	`SST_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY))
	`SST_ASSERT_NEXT(a_full_unchanged, clk, arst_n,
		done_q == 1'b0 && state_q == sst_pkg::FSM_EXEC && cmd_q == sst_pkg::CMD_INSERT
			&& !found_q && count_q >= CW'(CAPACITY), count_q == $past(count_q))

endmodule
